// ----- src/ihp_pkg.sv -----
package ihp_pkg;

   localparam int VERTEX_W    = 10;
   localparam int KEY_IN_W    = 32;
   localparam int COUNT_OUT_W = 11;
   localparam int DEGREE_W    = 3;
   localparam logic [DEGREE_W-1:0] DEGREE_RESET = 3'd4;

   typedef enum logic [1:0] {
      FUNC_ADD      = 2'd0,
      FUNC_DECREASE = 2'd1,
      FUNC_EXTRACT  = 2'd2,
      FUNC_CLEAR    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_DUPLICATE = 2'd1,
      STAT_ABSENT    = 2'd2,
      STAT_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_CHK_ENTRY,
      S_CHK_DECIDE,
      S_UP_TEST,
      S_UP_DIV,
      S_UP_CMP,
      S_PLACE,
      S_X_TAKE,
      S_X_TEST,
      S_X_LAST,
      S_DN_INIT,
      S_DN_READ,
      S_DN_CMP,
      S_DN_END,
      S_FIN_READ,
      S_FIN_RESP
   } state_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_ACCEPT,
      CMD_SET_ABSENT,
      CMD_SET_DUP,
      CMD_SET_EMPTY,
      CMD_CLEAR,
      CMD_RD_SLOT,
      CMD_RD_ENTRY,
      CMD_ADD_NEW,
      CMD_DK_SET,
      CMD_DIV_START,
      CMD_RD_PARENT,
      CMD_MOVE_PARENT,
      CMD_PLACE,
      CMD_RD_ROOT,
      CMD_TAKE_ROOT,
      CMD_RD_LAST,
      CMD_LOAD_LAST,
      CMD_DOWN_INIT,
      CMD_RD_CHILD,
      CMD_CMP_CHILD,
      CMD_MOVE_BEST,
      CMD_RESPOND
   } dp_cmd_type;

   typedef struct packed {
      logic       req_ready;
      dp_cmd_type cmd;
   } dp_ctrl_type;

   typedef struct packed {
      logic     req_valid;
      func_type func;
      logic     in_range;
      logic     present;
      logic     key_less;
      logic     fill_zero;
      logic     slot_zero;
      logic     div_done;
      logic     parent_greater;
      logic     child_ok;
      logic     found;
      logic     rsp_free;
   } dp_stat_type;

endpackage

// ----- src/ihp_if.sv -----
interface ihp_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          func;
   logic [ihp_pkg::VERTEX_W-1:0]        vertex;
   logic [ihp_pkg::KEY_IN_W-1:0]        key;
   modport source (output valid, func, vertex, key, input ready);
   modport sink (input valid, func, vertex, key, output ready);
endinterface

interface ihp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          status;
   logic [ihp_pkg::VERTEX_W-1:0]        extracted_vertex;
   logic [ihp_pkg::VERTEX_W-1:0]        min_vertex;
   logic                                heap_empty;
   logic [ihp_pkg::COUNT_OUT_W-1:0]     entry_count;
   modport source (output valid, status, extracted_vertex, min_vertex, heap_empty,
                   entry_count, input ready);
   modport sink (input valid, status, extracted_vertex, min_vertex, heap_empty,
                 entry_count, output ready);
endinterface

interface ihp_csr_if;
   logic                                valid;
   logic                                ready;
   logic [ihp_pkg::DEGREE_W-1:0]        heap_degree;
   modport source (output valid, heap_degree, input ready);
   modport sink (input valid, heap_degree, output ready);
endinterface

// ----- src/ihp_ram.sv -----
module ihp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/ihp_div.sv -----
module ihp_div #(
   parameter int NW = 10,
   parameter int DW = 3
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] numer,
   input  logic [DW-1:0] denom,
   output logic [NW-1:0] quot,
   output logic          done
);

   localparam int CTW = $clog2(NW + 1);

   logic [NW-1:0]  q_ff, q_in;
   logic [DW-1:0]  rem_ff, rem_in;
   logic [CTW-1:0] cnt_ff, cnt_in;
   logic           done_ff, done_in;
   logic [DW:0]    trial;
   logic [DW:0]    diff;
   logic           ge;

   // restoring division, one quotient bit a cycle
   always_comb begin
      trial   = {rem_ff, q_ff[NW-1]};
      ge      = trial >= {1'b0, denom};
      diff    = trial - {1'b0, denom};
      q_in    = q_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         q_in   = numer;
         rem_in = '0;
         cnt_in = CTW'(NW);
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? diff[DW-1:0] : trial[DW-1:0];
         q_in    = {q_ff[NW-2:0], ge};
         cnt_in  = cnt_ff - CTW'(1);
         done_in = (cnt_ff == CTW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
   end

   assign quot = q_ff;
   assign done = done_ff;

endmodule

// ----- src/ihp_fsm.sv -----
module ihp_fsm (
   input  logic                 clock,
   input  logic                 reset,
   input  ihp_pkg::dp_stat_type stat,
   output ihp_pkg::dp_ctrl_type ctrl
);

   ihp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ihp_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      ctrl.req_ready = 1'b0;
      ctrl.cmd       = ihp_pkg::CMD_NONE;
      unique case (state_ff)
         ihp_pkg::S_IDLE: begin
            ctrl.req_ready = 1'b1;
            if (stat.req_valid) begin
               ctrl.cmd = ihp_pkg::CMD_ACCEPT;
               state_in = ihp_pkg::S_DISPATCH;
            end
         end
         ihp_pkg::S_DISPATCH: begin
            unique case (stat.func)
               ihp_pkg::FUNC_ADD, ihp_pkg::FUNC_DECREASE: begin
                  if (!stat.in_range) begin
                     ctrl.cmd = ihp_pkg::CMD_SET_ABSENT;
                     state_in = ihp_pkg::S_FIN_READ;
                  end else begin
                     ctrl.cmd = ihp_pkg::CMD_RD_SLOT;
                     state_in = ihp_pkg::S_CHK_ENTRY;
                  end
               end
               ihp_pkg::FUNC_EXTRACT: begin
                  if (stat.fill_zero) begin
                     ctrl.cmd = ihp_pkg::CMD_SET_EMPTY;
                     state_in = ihp_pkg::S_FIN_READ;
                  end else begin
                     ctrl.cmd = ihp_pkg::CMD_RD_ROOT;
                     state_in = ihp_pkg::S_X_TAKE;
                  end
               end
               ihp_pkg::FUNC_CLEAR: begin
                  ctrl.cmd = ihp_pkg::CMD_CLEAR;
                  state_in = ihp_pkg::S_FIN_READ;
               end
               default: state_in = ihp_pkg::S_FIN_READ;
            endcase
         end
         ihp_pkg::S_CHK_ENTRY: begin
            ctrl.cmd = ihp_pkg::CMD_RD_ENTRY;
            state_in = ihp_pkg::S_CHK_DECIDE;
         end
         ihp_pkg::S_CHK_DECIDE: begin
            state_in = ihp_pkg::S_FIN_READ;
            if (stat.func == ihp_pkg::FUNC_ADD) begin
               if (stat.present) begin
                  ctrl.cmd = ihp_pkg::CMD_SET_DUP;
               end else begin
                  ctrl.cmd = ihp_pkg::CMD_ADD_NEW;
                  state_in = ihp_pkg::S_UP_TEST;
               end
            end else if (stat.present) begin
               if (stat.key_less) begin
                  ctrl.cmd = ihp_pkg::CMD_DK_SET;
                  state_in = ihp_pkg::S_UP_TEST;
               end
            end else begin
               // a slot entry never written reads as absent
               ctrl.cmd = ihp_pkg::CMD_SET_ABSENT;
            end
         end
         ihp_pkg::S_UP_TEST: begin
            if (stat.slot_zero) begin
               state_in = ihp_pkg::S_PLACE;
            end else begin
               ctrl.cmd = ihp_pkg::CMD_DIV_START;
               state_in = ihp_pkg::S_UP_DIV;
            end
         end
         ihp_pkg::S_UP_DIV: begin
            if (stat.div_done) begin
               ctrl.cmd = ihp_pkg::CMD_RD_PARENT;
               state_in = ihp_pkg::S_UP_CMP;
            end
         end
         ihp_pkg::S_UP_CMP: begin
            if (stat.parent_greater) begin
               ctrl.cmd = ihp_pkg::CMD_MOVE_PARENT;
               state_in = ihp_pkg::S_UP_TEST;
            end else begin
               state_in = ihp_pkg::S_PLACE;
            end
         end
         ihp_pkg::S_PLACE: begin
            ctrl.cmd = ihp_pkg::CMD_PLACE;
            state_in = ihp_pkg::S_FIN_READ;
         end
         ihp_pkg::S_X_TAKE: begin
            ctrl.cmd = ihp_pkg::CMD_TAKE_ROOT;
            state_in = ihp_pkg::S_X_TEST;
         end
         ihp_pkg::S_X_TEST: begin
            if (stat.fill_zero) begin
               state_in = ihp_pkg::S_FIN_READ;
            end else begin
               ctrl.cmd = ihp_pkg::CMD_RD_LAST;
               state_in = ihp_pkg::S_X_LAST;
            end
         end
         ihp_pkg::S_X_LAST: begin
            ctrl.cmd = ihp_pkg::CMD_LOAD_LAST;
            state_in = ihp_pkg::S_DN_INIT;
         end
         ihp_pkg::S_DN_INIT: begin
            ctrl.cmd = ihp_pkg::CMD_DOWN_INIT;
            state_in = ihp_pkg::S_DN_READ;
         end
         ihp_pkg::S_DN_READ: begin
            if (stat.child_ok) begin
               ctrl.cmd = ihp_pkg::CMD_RD_CHILD;
               state_in = ihp_pkg::S_DN_CMP;
            end else begin
               state_in = ihp_pkg::S_DN_END;
            end
         end
         ihp_pkg::S_DN_CMP: begin
            ctrl.cmd = ihp_pkg::CMD_CMP_CHILD;
            state_in = ihp_pkg::S_DN_READ;
         end
         ihp_pkg::S_DN_END: begin
            if (stat.found) begin
               ctrl.cmd = ihp_pkg::CMD_MOVE_BEST;
               state_in = ihp_pkg::S_DN_INIT;
            end else begin
               state_in = ihp_pkg::S_PLACE;
            end
         end
         ihp_pkg::S_FIN_READ: begin
            ctrl.cmd = ihp_pkg::CMD_RD_ROOT;
            state_in = ihp_pkg::S_FIN_RESP;
         end
         ihp_pkg::S_FIN_RESP: begin
            if (stat.rsp_free) begin
               ctrl.cmd = ihp_pkg::CMD_RESPOND;
               state_in = ihp_pkg::S_IDLE;
            end
         end
         default: state_in = ihp_pkg::S_IDLE;
      endcase
   end

endmodule

// ----- src/ihp_datapath.sv -----
module ihp_datapath #(
   parameter int VERTEX_COUNT = 1024,
   parameter int MAX_DEGREE   = 4,
   parameter int KEY_BITS     = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   ihp_req_if.sink              req,
   ihp_rsp_if.source            rsp,
   ihp_csr_if.sink              csr,
   input  ihp_pkg::dp_ctrl_type ctrl,
   output ihp_pkg::dp_stat_type stat
);

   localparam int SW  = $clog2(VERTEX_COUNT);
   localparam int CW  = $clog2(VERTEX_COUNT + 1);
   localparam int DW  = $clog2(MAX_DEGREE + 1);
   localparam int CXW = SW + DW + 1;
   localparam int VW  = ihp_pkg::VERTEX_W;
   localparam int HW  = VW + KEY_BITS;

   logic [ihp_pkg::DEGREE_W-1:0] deg_ff, deg_in;
   logic [CW-1:0]                fill_ff, fill_in;
   ihp_pkg::func_type            func_ff, func_in;
   logic [VW-1:0]                vertex_ff, vertex_in;
   logic [KEY_BITS-1:0]          key_ff, key_in;
   ihp_pkg::status_type          status_ff, status_in;
   logic [VW-1:0]                extr_ff, extr_in;
   logic [SW-1:0]                slot_ff, slot_in;
   logic [VW-1:0]                ent_v_ff, ent_v_in;
   logic [KEY_BITS-1:0]          ent_k_ff, ent_k_in;
   logic [VW-1:0]                best_v_ff, best_v_in;
   logic [KEY_BITS-1:0]          best_k_ff, best_k_in;
   logic [SW-1:0]                best_s_ff, best_s_in;
   logic                         found_ff, found_in;
   logic [DW-1:0]                idx_ff, idx_in;
   logic [CXW-1:0]               child_ff, child_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   ihp_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [VW-1:0]                rsp_extr_ff, rsp_extr_in;
   logic [VW-1:0]                rsp_min_ff, rsp_min_in;
   logic                         rsp_empty_ff, rsp_empty_in;
   logic [ihp_pkg::COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [DW-1:0]  deg_eff;
   logic           heap_we, heap_re, slot_we, slot_re;
   logic [SW-1:0]  heap_wa, heap_ra, slot_wa;
   logic [HW-1:0]  heap_wd, heap_rd;
   logic [SW-1:0]  slot_wd, slot_rd;
   logic [VW-1:0]  rd_v;
   logic [KEY_BITS-1:0] rd_k;
   logic           div_start, div_done;
   logic [SW-1:0]  div_quot;

   assign rd_v = heap_rd[HW-1:KEY_BITS];
   assign rd_k = heap_rd[KEY_BITS-1:0];

   // out-of-range degree is clamped
   always_comb begin
      if (deg_ff < 3'd2) begin
         deg_eff = DW'(2);
      end else if (32'(deg_ff) > MAX_DEGREE) begin
         deg_eff = DW'(MAX_DEGREE);
      end else begin
         deg_eff = DW'(deg_ff);
      end
   end

   ihp_ram #(.WIDTH(HW), .DEPTH(VERTEX_COUNT)) u_heap_ram (
      .clock   (clock),
      .wr_en   (heap_we),
      .wr_addr (heap_wa),
      .wr_data (heap_wd),
      .rd_en   (heap_re),
      .rd_addr (heap_ra),
      .rd_data (heap_rd)
   );

   ihp_ram #(.WIDTH(SW), .DEPTH(VERTEX_COUNT)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_wa),
      .wr_data (slot_wd),
      .rd_en   (slot_re),
      .rd_addr (SW'(vertex_ff)),
      .rd_data (slot_rd)
   );

   ihp_div #(.NW(SW), .DW(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (slot_ff - SW'(1)),
      .denom (deg_eff),
      .quot  (div_quot),
      .done  (div_done)
   );

   always_comb begin
      deg_in        = deg_ff;
      fill_in       = fill_ff;
      func_in       = func_ff;
      vertex_in     = vertex_ff;
      key_in        = key_ff;
      status_in     = status_ff;
      extr_in       = extr_ff;
      slot_in       = slot_ff;
      ent_v_in      = ent_v_ff;
      ent_k_in      = ent_k_ff;
      best_v_in     = best_v_ff;
      best_k_in     = best_k_ff;
      best_s_in     = best_s_ff;
      found_in      = found_ff;
      idx_in        = idx_ff;
      child_in      = child_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_extr_in   = rsp_extr_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_count_in  = rsp_count_ff;
      heap_we       = 1'b0;
      heap_wa       = slot_ff;
      heap_wd       = {ent_v_ff, ent_k_ff};
      heap_re       = 1'b0;
      heap_ra       = '0;
      slot_we       = 1'b0;
      slot_wa       = SW'(ent_v_ff);
      slot_wd       = slot_ff;
      slot_re       = 1'b0;
      div_start     = 1'b0;

      if (csr.valid) begin
         deg_in = csr.heap_degree;
      end

      unique case (ctrl.cmd)
         ihp_pkg::CMD_NONE: ;
         ihp_pkg::CMD_ACCEPT: begin
            func_in   = ihp_pkg::func_type'(req.func);
            vertex_in = req.vertex;
            key_in    = KEY_BITS'(req.key);
            status_in = ihp_pkg::STAT_OK;
            extr_in   = '0;
         end
         ihp_pkg::CMD_SET_ABSENT: status_in = ihp_pkg::STAT_ABSENT;
         ihp_pkg::CMD_SET_DUP:    status_in = ihp_pkg::STAT_DUPLICATE;
         ihp_pkg::CMD_SET_EMPTY:  status_in = ihp_pkg::STAT_EMPTY;
         ihp_pkg::CMD_CLEAR:      fill_in = '0;
         ihp_pkg::CMD_RD_SLOT:    slot_re = 1'b1;
         ihp_pkg::CMD_RD_ENTRY: begin
            heap_re = 1'b1;
            heap_ra = slot_rd;
         end
         ihp_pkg::CMD_ADD_NEW: begin
            slot_in  = SW'(fill_ff);
            ent_v_in = vertex_ff;
            ent_k_in = key_ff;
            fill_in  = fill_ff + CW'(1);
         end
         ihp_pkg::CMD_DK_SET: begin
            slot_in  = slot_rd;
            ent_v_in = vertex_ff;
            ent_k_in = key_ff;
         end
         ihp_pkg::CMD_DIV_START: div_start = 1'b1;
         ihp_pkg::CMD_RD_PARENT: begin
            heap_re = 1'b1;
            heap_ra = div_quot;
         end
         ihp_pkg::CMD_MOVE_PARENT: begin
            heap_we = 1'b1;
            heap_wd = heap_rd;
            slot_we = 1'b1;
            slot_wa = SW'(rd_v);
            slot_in = div_quot;
         end
         ihp_pkg::CMD_PLACE: begin
            heap_we = 1'b1;
            slot_we = 1'b1;
         end
         ihp_pkg::CMD_RD_ROOT: begin
            heap_re = 1'b1;
            heap_ra = '0;
         end
         ihp_pkg::CMD_TAKE_ROOT: begin
            extr_in = rd_v;
            fill_in = fill_ff - CW'(1);
         end
         ihp_pkg::CMD_RD_LAST: begin
            heap_re = 1'b1;
            heap_ra = SW'(fill_ff);
         end
         ihp_pkg::CMD_LOAD_LAST: begin
            ent_v_in = rd_v;
            ent_k_in = rd_k;
            slot_in  = '0;
         end
         ihp_pkg::CMD_DOWN_INIT: begin
            best_k_in = ent_k_ff;
            found_in  = 1'b0;
            idx_in    = '0;
            child_in  = CXW'(deg_eff) * CXW'(slot_ff) + CXW'(1);
         end
         ihp_pkg::CMD_RD_CHILD: begin
            heap_re = 1'b1;
            heap_ra = child_ff[SW-1:0];
         end
         ihp_pkg::CMD_CMP_CHILD: begin
            // first strictly smaller child wins ties
            if (best_k_ff > rd_k) begin
               best_k_in = rd_k;
               best_v_in = rd_v;
               best_s_in = child_ff[SW-1:0];
               found_in  = 1'b1;
            end
            idx_in   = idx_ff + DW'(1);
            child_in = child_ff + CXW'(1);
         end
         ihp_pkg::CMD_MOVE_BEST: begin
            heap_we = 1'b1;
            heap_wd = {best_v_ff, best_k_ff};
            slot_we = 1'b1;
            slot_wa = SW'(best_v_ff);
            slot_in = best_s_ff;
         end
         ihp_pkg::CMD_RESPOND: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_extr_in   = extr_ff;
            rsp_min_in    = (fill_ff != '0) ? rd_v : '0;
            rsp_empty_in  = (fill_ff == '0);
            rsp_count_in  = ihp_pkg::COUNT_OUT_W'(fill_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deg_ff       <= ihp_pkg::DEGREE_RESET;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         deg_ff       <= deg_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      vertex_ff     <= vertex_in;
      key_ff        <= key_in;
      status_ff     <= status_in;
      extr_ff       <= extr_in;
      slot_ff       <= slot_in;
      ent_v_ff      <= ent_v_in;
      ent_k_ff      <= ent_k_in;
      best_v_ff     <= best_v_in;
      best_k_ff     <= best_k_in;
      best_s_ff     <= best_s_in;
      found_ff      <= found_in;
      idx_ff        <= idx_in;
      child_ff      <= child_in;
      rsp_status_ff <= rsp_status_in;
      rsp_extr_ff   <= rsp_extr_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // a vertex is held when its slot lies below the fill and points back at it
   always_comb begin
      stat.req_valid      = req.valid;
      stat.func           = func_ff;
      stat.in_range       = 32'(vertex_ff) < VERTEX_COUNT;
      stat.present        = (CW'(slot_rd) < fill_ff) && (rd_v == vertex_ff);
      stat.key_less       = key_ff < rd_k;
      stat.fill_zero      = (fill_ff == '0);
      stat.slot_zero      = (slot_ff == '0);
      stat.div_done       = div_done;
      stat.parent_greater = rd_k > ent_k_ff;
      stat.child_ok       = (idx_ff < deg_eff) && (child_ff < CXW'(fill_ff));
      stat.found          = found_ff;
      stat.rsp_free       = !rsp_valid_ff || rsp.ready;
   end

   assign req.ready            = ctrl.req_ready;
   assign csr.ready            = 1'b1;
   assign rsp.valid            = rsp_valid_ff;
   assign rsp.status           = rsp_status_ff;
   assign rsp.extracted_vertex = rsp_extr_ff;
   assign rsp.min_vertex       = rsp_min_ff;
   assign rsp.heap_empty       = rsp_empty_ff;
   assign rsp.entry_count      = rsp_count_ff;

endmodule

// ----- src/indexed_dary_min_heap.sv -----
// channel  dir  transfer when        payload
// req      in   req.valid & ready    func, vertex, key
// rsp      out  rsp.valid & ready    status, extracted_vertex, min_vertex,
//                                    heap_empty, entry_count
// csr      in   csr.valid & ready    heap_degree (always ready)
//
// one operation at a time; add and decrease sift up, extract sifts down
// sift up: per level a parent index divide, then a parent read and compare
// sift down: per level the children are read one at a time from the single heap ram read port
// clear zeroes the fill count; no clearing pass after reset
// a held result does not block the next request; a stalled result delays completion
module indexed_dary_min_heap #(
   parameter int VERTEX_COUNT = 1024,
   parameter int MAX_DEGREE   = 4,
   parameter int KEY_BITS     = 32
) (
   input  logic      clock,
   input  logic      reset,
   ihp_req_if.sink   req,
   ihp_rsp_if.source rsp,
   ihp_csr_if.sink   csr
);

   ihp_pkg::dp_ctrl_type ctrl;
   ihp_pkg::dp_stat_type stat;

   ihp_fsm u_fsm (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   ihp_datapath #(
      .VERTEX_COUNT (VERTEX_COUNT),
      .MAX_DEGREE   (MAX_DEGREE),
      .KEY_BITS     (KEY_BITS)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr),
      .ctrl  (ctrl),
      .stat  (stat)
   );

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (32'(rsp.entry_count) <= VERTEX_COUNT))
      else $error("entry count above capacity");
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.heap_empty == (rsp.entry_count == '0)))
      else $error("empty flag disagrees with count");
   a_empty_min: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.heap_empty) |-> (rsp.min_vertex == '0))
      else $error("min vertex on empty heap");
   a_extract_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.extracted_vertex != '0) |-> (rsp.status == ihp_pkg::STAT_OK))
      else $error("extracted vertex with failing status");
`endif

endmodule
